FILE: design/stack_allocator_deferred_free_top_assert.svh
// Assertion macros for the stack allocator with deferred free.
// Used by the top level; no other dependencies.
`ifndef STACK_ALLOCATOR_DEFERRED_FREE_TOP_ASSERT_SVH
`define STACK_ALLOCATOR_DEFERRED_FREE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SADF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SADF_ASSERT_IMPL(label, ante, cons, msg) \
  `SADF_ASSERT(label, (ante) |-> (cons), msg)
`else
`define SADF_ASSERT(label, prop, msg)
`define SADF_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

FILE: design/sadf_pkg.sv
// Types and constants for the stack allocator with deferred free.
// Used by stack_allocator_deferred_free_top; depends on nothing.
package sadf_pkg;

  // Slot count and heap address width are tied to the fixed field widths below.
  localparam int unsigned MAX_SLOTS      = 64;
  localparam int unsigned HEAP_ADDR_BITS = 20;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned SIZE_W     = 21;
  localparam int unsigned SLOT_IN_W  = 6;
  localparam int unsigned ADDR_OUT_W = 20;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [SIZE_W-1:0] HEAP_SIZE_RESET = 21'd1048576;

  typedef enum logic [KIND_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_NO_SPACE = 3'd1,
    STAT_ZERO     = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_BAD      = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_CASC = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  // Input beat payload, first field in the highest bits.
  typedef struct packed {
    logic [SIZE_W-1:0]    query_addr;
    logic [SLOT_IN_W-1:0] slot;
    logic [SIZE_W-1:0]    req_size;
  } in_beat_t;

  // Result beat payload, first field in the highest bits.
  typedef struct packed {
    logic [4:0]            pad;
    logic [SIZE_W-1:0]     top_now;
    logic                  contained;
    logic [SLOT_IN_W-1:0]  block_slot;
    logic [ADDR_OUT_W-1:0] block_addr;
    status_e               status;
  } result_t;

endpackage

FILE: design/stack_allocator_deferred_free_top.sv
// Stack allocator with deferred free: top pointer, slot count and a slot memory.
// Depends on sadf_pkg and stack_allocator_deferred_free_top_assert.svh.
//
// Usage: requests arrive on the s_axis channel, one beat per operation, with the
// operation kind on tuser (alloc, free, clear, contains). Every request gives
// exactly one result beat on the m_axis channel, in request order. The heap size
// register is written through the cfg channel, which is always ready; write it
// only while no request is in flight.
// Every request is registered on acceptance, has its result registered in the
// execute state and is moved into the output register in the done state. A
// successful free of the top block goes through a cascade state in between,
// unless the stack is then empty; each cascade step pops the next slot beneath
// if it was freed, and a live slot or an empty stack ends it. A new request is
// taken once the previous one has been placed in the output register. The slot
// memory has one registered read port; each cascade step is one read of it.
// Reset clears the top pointer, the slot count and the output valid flag and sets
// the heap size to 1048576; the slot memory is not cleared and needs no sweep.
// When the receiver stalls, the result waits in the output register; the block
// still accepts and works on the next request, then holds until the output
// register frees up.
`include "stack_allocator_deferred_free_top_assert.svh"

module stack_allocator_deferred_free_top
  import sadf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [SIZE_W-1:0]     cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // req_size[20:0], slot[26:21], query_addr[47:27]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind[1:0]
  input  logic [KIND_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status[2:0], block_addr[22:3], block_slot[28:23], contained[29],
  // top_now[50:30], zero[55:51]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned SLOT_W = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned ENT_W  = SIZE_W + 1;
  localparam logic [32:0] HEAP_CAP = 33'(1) << HEAP_ADDR_BITS;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SLOTS);

  state_e            state_q, state_d;
  logic [SIZE_W-1:0] heap_q;
  logic [SIZE_W-1:0] top_q, top_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  op_e               op_q;
  in_beat_t          beat_q;
  result_t           res_q, res_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_data_q, out_data_d;

  // Slot memory entry: {freed, bytes}.
  logic [ENT_W-1:0]  mem_q [MAX_SLOTS];
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [ENT_W-1:0]  wr_data;
  logic [SLOT_W-1:0] rd_addr_d;
  logic [ENT_W-1:0]  rd_data_q;

  in_beat_t          in_beat;
  logic              in_fire;
  logic [SIZE_W-1:0] eff_heap;
  logic [SIZE_W-1:0] avail;
  logic [SIZE_W-1:0] rd_bytes;
  logic              rd_freed;
  logic [SIZE_W-1:0] top_pop;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CNT_W-1:0]  cnt_dec2;
  logic              slot_live;
  logic              slot_is_top;
  logic              out_free;

  assign in_beat       = in_beat_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  // The heap never reaches beyond the address space.
  assign eff_heap = (33'(heap_q) > HEAP_CAP) ? SIZE_W'(HEAP_CAP) : heap_q;
  assign avail    = (eff_heap > top_q) ? (eff_heap - top_q) : '0;

  assign rd_bytes    = rd_data_q[SIZE_W-1:0];
  assign rd_freed    = rd_data_q[SIZE_W];
  assign top_pop     = (rd_bytes > top_q) ? '0 : (top_q - rd_bytes);
  assign cnt_dec     = cnt_q - CNT_W'(1);
  assign cnt_dec2    = cnt_q - CNT_W'(2);
  assign slot_live   = 32'(beat_q.slot) < 32'(cnt_q);
  assign slot_is_top = (32'(beat_q.slot) + 32'd1) == 32'(cnt_q);

  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    wr_en       = 1'b0;
    wr_addr     = cnt_q[SLOT_W-1:0];
    wr_data     = {1'b0, beat_q.req_size};
    rd_addr_d   = cnt_dec2[SLOT_W-1:0];
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    unique case (state_q)
      ST_IDLE: begin
        rd_addr_d = SLOT_W'(in_beat.slot);
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_d   = '0;
        state_d = ST_DONE;
        unique case (op_q)
          OP_ALLOC: begin
            if (beat_q.req_size == '0) begin
              res_d.status = STAT_ZERO;
            end else if (beat_q.req_size > avail) begin
              res_d.status = STAT_NO_SPACE;
            end else if (cnt_q == CNT_FULL) begin
              res_d.status = STAT_FULL;
            end else begin
              wr_en            = 1'b1;
              res_d.block_addr = top_q[ADDR_OUT_W-1:0];
              res_d.block_slot = SLOT_IN_W'(cnt_q);
              cnt_d            = cnt_q + CNT_W'(1);
              top_d            = top_q + beat_q.req_size;
            end
          end
          OP_FREE: begin
            if (!slot_live || rd_freed) begin
              res_d.status = STAT_BAD;
            end else if (!slot_is_top) begin
              wr_en   = 1'b1;
              wr_addr = SLOT_W'(beat_q.slot);
              wr_data = {1'b1, rd_bytes};
            end else begin
              // Popping the top block; look at the slot beneath it next.
              cnt_d = cnt_dec;
              top_d = top_pop;
              if (cnt_dec != '0) begin
                state_d = ST_CASC;
              end
            end
          end
          OP_CLEAR: begin
            top_d = '0;
            cnt_d = '0;
          end
          OP_QUERY: begin
            res_d.contained = (beat_q.query_addr < eff_heap);
          end
          default: ;
        endcase
      end
      ST_CASC: begin
        // rd_data_q holds the slot just below the current top.
        if (rd_freed) begin
          cnt_d = cnt_dec;
          top_d = top_pop;
          if (cnt_dec == '0) begin
            state_d = ST_DONE;
          end
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_data_d         = res_q;
          out_data_d.top_now = top_q;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      heap_q      <= HEAP_SIZE_RESET;
      top_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid && cfg_ready) begin
        heap_q <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= op_e'(s_axis_tuser);
      beat_q <= in_beat;
    end
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr_d];
  end

  `SADF_ASSERT(a_cnt_bound, cnt_q <= CNT_FULL, "slot count above capacity")
  `SADF_ASSERT_IMPL(a_empty_top, cnt_q == '0, top_q == '0, "empty stack with nonzero top")
  `SADF_ASSERT_IMPL(a_casc_live, state_q == ST_CASC, cnt_q != '0, "cascade on empty stack")
  `SADF_ASSERT_IMPL(a_out_src, $rose(out_valid_q), $past(state_q == ST_DONE),
                    "result raised outside the done step")

endmodule

FILE: test/tb_stack_allocator_deferred_free_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for stack_allocator_deferred_free_top: a local allocator
// model predicts each result beat, which is compared field by field with the DUT.
// Depends on sadf_pkg and the design files; reads nothing at run time.
module tb_stack_allocator_deferred_free_top;
  import sadf_pkg::*;

  localparam int MAX_SLOT_COUNT = 64;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // req_size[20:0], slot[26:21], query_addr[47:27]
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  // kind[1:0]
  logic [KIND_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // status[2:0], block_addr[22:3], block_slot[28:23], contained[29], top_now[50:30]
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  stack_allocator_deferred_free_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Allocator model state, updated as each request beat is accepted.
  logic [SIZE_W-1:0] heap_size_q = HEAP_SIZE_RESET;
  logic [SIZE_W-1:0] top_q = '0;
  logic [6:0]        live_slots = '0;
  logic [SIZE_W-1:0] slot_len [MAX_SLOT_COUNT];
  logic              slot_freed_q [MAX_SLOT_COUNT];

  result_t pending_results [$];
  int fail_count = 0;
  int quiet_cycles = 0;
  bit idle_en = 1'b1;
  int sink_hold_cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned effective_heap();
    return (heap_size_q > 21'd1048576) ? 1048576 : int'(heap_size_q);
  endfunction

  function automatic result_t allocator_result(input op_e kind, input logic [SIZE_W-1:0] size,
                                               input logic [5:0] slot,
                                               input logic [SIZE_W-1:0] addr);
    result_t r;
    logic [SIZE_W-1:0] heap;
    logic [SIZE_W-1:0] avail;
    r = '0;
    r.status = STAT_OK;
    heap = SIZE_W'(effective_heap());
    avail = (heap > top_q) ? heap - top_q : '0;
    case (kind)
      OP_ALLOC: begin
        if (size == '0) r.status = STAT_ZERO;
        else if (size > avail) r.status = STAT_NO_SPACE;
        else if (live_slots >= MAX_SLOT_COUNT) r.status = STAT_FULL;
        else begin
          r.block_addr = top_q[ADDR_OUT_W-1:0];
          r.block_slot = live_slots[5:0];
          slot_len[live_slots] = size;
          slot_freed_q[live_slots] = 1'b0;
          live_slots++;
          top_q = top_q + size;
        end
      end
      OP_FREE: begin
        if (slot >= live_slots || slot_freed_q[slot]) r.status = STAT_BAD;
        else if (slot + 1 != live_slots) slot_freed_q[slot] = 1'b1;
        else begin
          // Pop the top block, then every freed block right beneath it.
          do begin
            live_slots--;
            top_q = (slot_len[live_slots] > top_q) ? '0 : top_q - slot_len[live_slots];
          end while (live_slots > 0 && slot_freed_q[live_slots - 1]);
        end
      end
      OP_CLEAR: begin
        top_q = '0;
        live_slots = '0;
      end
      default: r.contained = (addr < heap);
    endcase
    r.top_now = top_q;
    return r;
  endfunction

  // Sends one request beat and records its expected result once accepted.
  task automatic send_op(input op_e kind, input logic [SIZE_W-1:0] size,
                         input logic [5:0] slot, input logic [SIZE_W-1:0] addr);
    in_beat_t beat;
    int gap;
    beat.req_size = size;
    beat.slot = slot;
    beat.query_addr = addr;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= beat;
    s_axis_tuser <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(allocator_result(kind, size, slot, addr));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_heap_size(input logic [SIZE_W-1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
    heap_size_q = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(0, 99);
    span = effective_heap() / 24;
    if (span == 0) span = 1;
    if (pick < 3) return '0;
    if (pick < 8) return SIZE_W'($urandom);
    if (pick < 14) return SIZE_W'($urandom_range(1, 1048576));
    return SIZE_W'($urandom_range(1, span));
  endfunction

  function automatic logic [SIZE_W-1:0] pick_addr();
    int unsigned pick;
    int unsigned heap;
    pick = $urandom_range(0, 99);
    heap = effective_heap();
    if (pick < 20) return SIZE_W'(heap - 1 + $urandom_range(0, 2));
    if (pick < 60) return SIZE_W'($urandom_range(0, 2 * heap));
    return SIZE_W'($urandom);
  endfunction

  task automatic send_random_op();
    int unsigned pick;
    logic [5:0] slot;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_op(OP_ALLOC, pick_size(), 6'($urandom), SIZE_W'($urandom));
    end else if (pick < 80) begin
      if (live_slots == 0 || $urandom_range(0, 9) == 0) slot = 6'($urandom);
      else if ($urandom_range(0, 2) == 0) slot = 6'(live_slots - 1);
      else slot = 6'($urandom_range(0, live_slots - 1));
      send_op(OP_FREE, SIZE_W'($urandom), slot, SIZE_W'($urandom));
    end else if (pick < 95) begin
      send_op(OP_QUERY, SIZE_W'($urandom), 6'($urandom), pick_addr());
    end else begin
      send_op(OP_CLEAR, SIZE_W'($urandom), 6'($urandom), SIZE_W'($urandom));
    end
  endtask

  task automatic test_directed_ops();
    send_op(OP_QUERY, '0, '0, 21'd1048575);
    send_op(OP_QUERY, '0, '0, 21'd1048576);
    send_op(OP_ALLOC, '0, '0, '0);
    send_op(OP_ALLOC, 21'h1FFFFF, '0, '0);
    send_op(OP_ALLOC, 21'd1048576, '0, '0);
    send_op(OP_ALLOC, 21'd1, '0, '0);
    send_op(OP_FREE, '0, 6'd0, '0);
    send_op(OP_ALLOC, 21'd16, '0, '0);
    send_op(OP_ALLOC, 21'd32, '0, '0);
    send_op(OP_ALLOC, 21'd48, '0, '0);
    send_op(OP_FREE, '0, 6'd1, '0);
    // Double free and handles beyond the stack are rejected.
    send_op(OP_FREE, '0, 6'd1, '0);
    send_op(OP_FREE, '0, 6'd5, '0);
    send_op(OP_FREE, '0, 6'd63, '0);
    send_op(OP_FREE, '0, 6'd2, '0);
    send_op(OP_ALLOC, 21'd100, '0, '0);
    send_op(OP_CLEAR, '0, '0, '0);
    send_op(OP_FREE, '0, 6'd0, '0);
  endtask

  task automatic test_heap_size_extremes();
    drain_results();
    write_heap_size('0);
    send_op(OP_ALLOC, 21'd1, '0, '0);
    send_op(OP_QUERY, '0, '0, '0);
    drain_results();
    write_heap_size(21'h1FFFFF);
    send_op(OP_ALLOC, 21'd1048576, '0, '0);
    send_op(OP_QUERY, '0, '0, 21'd1048576);
    // Shrinking the heap below the top leaves no free space.
    drain_results();
    write_heap_size(21'd500);
    send_op(OP_ALLOC, 21'd1, '0, '0);
    send_op(OP_CLEAR, '0, '0, '0);
    send_op(OP_ALLOC, 21'd400, '0, '0);
    drain_results();
    write_heap_size(21'd100);
    send_op(OP_ALLOC, 21'd1, '0, '0);
    send_op(OP_FREE, '0, 6'd0, '0);
  endtask

  // Fills every slot, probes the full stack, then frees in random order so that
  // top frees cascade over runs of freed blocks of varying length.
  task automatic test_fill_and_cascade(input logic [SIZE_W-1:0] heap);
    int unsigned span;
    drain_results();
    write_heap_size(heap);
    send_op(OP_CLEAR, SIZE_W'($urandom), 6'($urandom), SIZE_W'($urandom));
    span = effective_heap() / 80;
    if (span == 0) span = 1;
    while (live_slots < MAX_SLOT_COUNT) begin
      if ($urandom_range(0, 9) == 0)
        send_op(OP_QUERY, SIZE_W'($urandom), 6'($urandom), pick_addr());
      else
        send_op(OP_ALLOC, SIZE_W'($urandom_range(1, span)), 6'($urandom), SIZE_W'($urandom));
    end
    send_op(OP_ALLOC, 21'd1, '0, '0);
    send_op(OP_ALLOC, 21'h1FFFFF, '0, '0);
    send_op(OP_ALLOC, '0, '0, '0);
    while (live_slots > 0) begin
      if (live_slots > 1) begin
        repeat (live_slots) begin
          send_op(OP_FREE, SIZE_W'($urandom), 6'($urandom_range(0, live_slots - 2)),
                  SIZE_W'($urandom));
        end
      end
      send_op(OP_FREE, SIZE_W'($urandom), 6'(live_slots - 1), SIZE_W'($urandom));
    end
  endtask

  task automatic test_random_mix();
    logic [SIZE_W-1:0] heaps [5];
    int counts [5];
    heaps = '{21'd4096, 21'd300, 21'd1, 21'h1FFFFF, 21'd65536};
    counts = '{40, 30, 10, 30, 30};
    for (int i = 0; i < 5; i++) begin
      drain_results();
      write_heap_size(heaps[i]);
      repeat (counts[i]) send_random_op();
    end
  endtask

  // The sink holds off long enough for the DUT to stall its input, then the
  // sender waits for every outstanding result before going on.
  task automatic test_output_stall();
    drain_results();
    idle_en = 1'b0;
    sink_hold_cycles = 150;
    repeat (16) send_random_op();
    drain_results();
    idle_en = 1'b1;
  endtask

  task automatic test_steady_stream();
    drain_results();
    write_heap_size(HEAP_SIZE_RESET);
    idle_en = 1'b0;
    repeat (100) send_random_op();
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold_cycles--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        $error("result beat with no request outstanding: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_count++;
        end
        if (got.block_addr !== want.block_addr) begin
          $error("block_addr: expected %0d, got %0d", want.block_addr, got.block_addr);
          fail_count++;
        end
        if (got.block_slot !== want.block_slot) begin
          $error("block_slot: expected %0d, got %0d", want.block_slot, got.block_slot);
          fail_count++;
        end
        if (got.contained !== want.contained) begin
          $error("contained: expected %0d, got %0d", want.contained, got.contained);
          fail_count++;
        end
        if (got.top_now !== want.top_now) begin
          $error("top_now: expected %0d, got %0d", want.top_now, got.top_now);
          fail_count++;
        end
      end
    end
  end

  // Ends the run if no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < MAX_SLOT_COUNT; i++) begin
      slot_len[i] = '0;
      slot_freed_q[i] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_ops();
    test_heap_size_extremes();
    test_fill_and_cascade(21'd1048576);
    test_fill_and_cascade(21'd300);
    test_random_mix();
    test_output_stall();
    test_steady_stream();
    drain_results();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/sadf_pkg.sv
design/stack_allocator_deferred_free_top.sv
test/tb_stack_allocator_deferred_free_top.sv
